// ===== src/md4_pkg.sv =====
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and the microcode program of the MD4 hash core.
// ----------------------------------------------------------------------------
`default_nettype none

package md4_pkg;

  // chaining word start values
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // round constants
  localparam logic [31:0] K_R1 = 32'h00000000;
  localparam logic [31:0] K_R2 = 32'h5A827999;
  localparam logic [31:0] K_R3 = 32'h6ED9EBA1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int PC_W = 6;

  // micro-operations
  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_ROUND = 3'd2;
  localparam logic [2:0] OP_CHAIN = 3'd3;
  localparam logic [2:0] OP_PAD80 = 3'd4;
  localparam logic [2:0] OP_PADZ  = 3'd5;
  localparam logic [2:0] OP_LEN   = 3'd6;
  localparam logic [2:0] OP_EMIT  = 3'd7;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE   = 6'd0;
  localparam logic [PC_W-1:0] PC_LOAD   = 6'd1;
  localparam logic [PC_W-1:0] PC_ROUND0 = 6'd2;
  localparam logic [PC_W-1:0] PC_ROUNDN = 6'd49;
  localparam logic [PC_W-1:0] PC_CHAIN  = 6'd50;
  localparam logic [PC_W-1:0] PC_PAD80  = 6'd51;
  localparam logic [PC_W-1:0] PC_PADZ   = 6'd52;
  localparam logic [PC_W-1:0] PC_LEN    = 6'd53;
  localparam logic [PC_W-1:0] PC_EMIT   = 6'd54;

  // padding stops here, the length takes the last eight bytes
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [5:0] BLOCK_END = 6'd63;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } msg_beat_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } digest_beat_t;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] widx;
    logic [4:0] rot;
    logic [1:0] rnd;
  } ucode_t;

  typedef struct packed {
    logic pos_last;    // fill position is the last byte of a block
    logic ptr_at_len;  // pad pointer reached the length field
    logic ptr_at_end;  // pad pointer at the last byte of a block
    logic out_free;    // digest register can take a new result
  } seq_status_t;

  localparam logic [3:0] WORD_SEL [48] = '{
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
    4'd0, 4'd4, 4'd8, 4'd12, 4'd1, 4'd5, 4'd9, 4'd13,
    4'd2, 4'd6, 4'd10, 4'd14, 4'd3, 4'd7, 4'd11, 4'd15,
    4'd0, 4'd8, 4'd4, 4'd12, 4'd2, 4'd10, 4'd6, 4'd14,
    4'd1, 4'd9, 4'd5, 4'd13, 4'd3, 4'd11, 4'd7, 4'd15
  };

  function automatic logic [4:0] rot_amount(input logic [1:0] rnd, input logic [1:0] pos);
    logic [4:0] r;
    case ({rnd, pos})
      4'h0: r = 5'd3;
      4'h1: r = 5'd7;
      4'h2: r = 5'd11;
      4'h3: r = 5'd19;
      4'h4: r = 5'd3;
      4'h5: r = 5'd5;
      4'h6: r = 5'd9;
      4'h7: r = 5'd13;
      4'h8: r = 5'd3;
      4'h9: r = 5'd9;
      4'hA: r = 5'd11;
      default: r = 5'd15;
    endcase
    return r;
  endfunction

  // microcode ROM: one control word per program address
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t u;
    logic [PC_W-1:0] step;
    step = pc - PC_ROUND0;
    u = '{op: OP_IDLE, widx: 4'd0, rot: 5'd0, rnd: 2'd0};
    unique case (pc)
      PC_IDLE:  u.op = OP_IDLE;
      PC_LOAD:  u.op = OP_LOAD;
      PC_CHAIN: u.op = OP_CHAIN;
      PC_PAD80: u.op = OP_PAD80;
      PC_PADZ:  u.op = OP_PADZ;
      PC_LEN:   u.op = OP_LEN;
      PC_EMIT:  u.op = OP_EMIT;
      default: begin
        if (pc >= PC_ROUND0 && pc <= PC_ROUNDN) begin
          u.op   = OP_ROUND;
          u.rnd  = step[5:4];
          u.widx = WORD_SEL[step];
          u.rot  = rot_amount(step[5:4], step[1:0]);
        end
      end
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== src/md4_stream_if.sv =====
// ----------------------------------------------------------------------------
// md4_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface md4_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/md4_hash_core_top.sv =====
// ----------------------------------------------------------------------------
// md4_hash_core_top
// MD4 message digest core, one message byte per beat.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the core sits in its idle step. The
// 64th byte of a block starts a compression that holds the input off: one
// load, 48 round steps through a single round unit, one chaining add. A beat
// with last set runs the padding sequencer: a step for the 0x80 byte, a step
// for each zero byte, a step that finds the length field and one that
// writes the length, then a compression and a step that loads the digest
// register. When the 0x80 byte lands at byte 56 or later, the zero fill runs
// to the end of the block and a compression sits between the two parts of
// the fill. A last byte that completes a block runs its own compression
// before the padding starts. The digest load waits for as long as the
// previous digest has not been taken. All timing comes from the microcode
// program walked by the step counter. The digest register sits apart from
// the input side, so a new message may start while a digest waits to be
// taken.
// ----------------------------------------------------------------------------
`default_nettype none

module md4_hash_core_top (
  input logic         clk,
  input logic         rst,
  md4_stream_if.sink   msg,
  md4_stream_if.source digest
);
  import md4_pkg::*;

  ucode_t       ctrl;
  seq_status_t  stat;
  msg_beat_t    beat_data;
  digest_beat_t digest_data;
  logic         digest_valid;
  logic         beat;

  assign beat_data = msg.payload;
  assign msg.ready = (ctrl.op == OP_IDLE);
  assign beat      = msg.valid && msg.ready;

  assign digest.valid   = digest_valid;
  assign digest.payload = digest_data;

  md4_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .beat_data (beat_data),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  md4_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .beat         (beat),
    .beat_data    (beat_data),
    .stat         (stat),
    .digest_data  (digest_data),
    .digest_valid (digest_valid),
    .digest_ready (digest.ready)
  );

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_EMIT && stat.out_free) |=> digest.valid)
    else $error("digest not presented after emit");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_LEN) |-> stat.ptr_at_len)
    else $error("length written at wrong pad position");

  a_full_block: assert property (@(posedge clk) disable iff (rst)
    (beat && beat_data.byte_present && stat.pos_last) |=> (ctrl.op == OP_LOAD))
    else $error("full block did not start compression");

endmodule

`default_nettype wire

// ===== src/md4_seq.sv =====
// ----------------------------------------------------------------------------
// md4_seq
// Microcode sequencer: program counter, ROM lookup and branch decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module md4_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                beat,
  input  md4_pkg::msg_beat_t  beat_data,
  input  md4_pkg::seq_status_t stat,
  output md4_pkg::ucode_t     ctrl
);
  import md4_pkg::*;

  logic [PC_W-1:0] pc, pc_next;
  logic fin, padded, len_done;

  assign ctrl = ucode_rom(pc);

  always_comb begin
    pc_next = pc;
    unique case (ctrl.op)
      OP_IDLE: begin
        if (beat) begin
          if (beat_data.byte_present && stat.pos_last) pc_next = PC_LOAD;
          else if (beat_data.last)                     pc_next = PC_PAD80;
        end
      end
      OP_LOAD, OP_ROUND: pc_next = PC_W'(pc + 6'd1);
      OP_CHAIN: begin
        if (!fin)          pc_next = PC_IDLE;
        else if (len_done) pc_next = PC_EMIT;
        else if (padded)   pc_next = PC_PADZ;
        else               pc_next = PC_PAD80;
      end
      // 0x80 in the last byte of a block: the block is full already
      OP_PAD80: pc_next = stat.ptr_at_end ? PC_LOAD : PC_PADZ;
      OP_PADZ: begin
        if (stat.ptr_at_len)      pc_next = PC_LEN;
        else if (stat.ptr_at_end) pc_next = PC_LOAD;
      end
      OP_LEN:  pc_next = PC_LOAD;
      OP_EMIT: pc_next = stat.out_free ? PC_IDLE : PC_EMIT;
      default: pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= PC_IDLE;
      fin      <= 1'b0;
      padded   <= 1'b0;
      len_done <= 1'b0;
    end else begin
      pc <= pc_next;
      if (ctrl.op == OP_IDLE && beat) begin
        fin      <= beat_data.last;
        padded   <= 1'b0;
        len_done <= 1'b0;
      end
      if (ctrl.op == OP_PAD80) padded <= 1'b1;
      if (ctrl.op == OP_LEN)   len_done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== src/md4_dp.sv =====
// ----------------------------------------------------------------------------
// md4_dp
// MD4 datapath: block buffer, byte count, pad pointer, working and chaining
// words, round function and the digest output register.
// ----------------------------------------------------------------------------
`default_nettype none

module md4_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  md4_pkg::ucode_t       ctrl,
  input  logic                  beat,
  input  md4_pkg::msg_beat_t    beat_data,
  output md4_pkg::seq_status_t  stat,
  output md4_pkg::digest_beat_t digest_data,
  output logic                  digest_valid,
  input  logic                  digest_ready
);
  import md4_pkg::*;

  logic [31:0] blk [16];
  logic [60:0] count, count_next;
  logic [5:0]  ptr;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] ca, cb, cc, cd;

  logic [31:0] f_val, k_val, sum, rnd_out;
  logic [63:0] rot_dbl;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic        emit_load;

  assign count_next = beat_data.byte_present ? 61'(count + 61'd1) : count;

  assign stat.pos_last   = (count[5:0] == BLOCK_END);
  assign stat.ptr_at_len = (ptr == LEN_POS);
  assign stat.ptr_at_end = (ptr == BLOCK_END);
  assign stat.out_free   = !digest_valid || digest_ready;

  assign emit_load = (ctrl.op == OP_EMIT) && stat.out_free;

  // round function
  always_comb begin
    case (ctrl.rnd)
      2'd0: begin
        f_val = (wb & wc) | (~wb & wd);
        k_val = K_R1;
      end
      2'd1: begin
        f_val = (wb & wc) | (wb & wd) | (wc & wd);
        k_val = K_R2;
      end
      default: begin
        f_val = wb ^ wc ^ wd;
        k_val = K_R3;
      end
    endcase
  end

  assign sum     = wa + f_val + blk[ctrl.widx] + k_val;
  assign rot_dbl = {sum, sum} << ctrl.rot;
  assign rnd_out = rot_dbl[63:32];

  // byte writes into the block buffer
  always_comb begin
    wr_en   = 1'b0;
    wr_pos  = ptr;
    wr_byte = 8'h00;
    if (ctrl.op == OP_IDLE && beat && beat_data.byte_present) begin
      wr_en   = 1'b1;
      wr_pos  = count[5:0];
      wr_byte = beat_data.data_byte;
    end else if (ctrl.op == OP_PAD80) begin
      wr_en   = 1'b1;
      wr_byte = PAD_BYTE;
    end else if (ctrl.op == OP_PADZ && !stat.ptr_at_len) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_pos[1:0] == 2'd0) blk[wr_pos[5:2]] <= {24'h0, wr_byte};
      else                     blk[wr_pos[5:2]][8*wr_pos[1:0] +: 8] <= wr_byte;
    end
    if (ctrl.op == OP_LEN) begin
      // bit length = byte count * 8, little-endian over two words
      blk[14] <= {count[28:0], 3'b000};
      blk[15] <= count[60:29];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ptr   <= '0;
      wa    <= '0;
      wb    <= '0;
      wc    <= '0;
      wd    <= '0;
      ca    <= IV_A;
      cb    <= IV_B;
      cc    <= IV_C;
      cd    <= IV_D;
    end else begin
      if (ctrl.op == OP_IDLE && beat) begin
        count <= count_next;
        ptr   <= count_next[5:0];
      end
      if (wr_en && ctrl.op != OP_IDLE) ptr <= 6'(ptr + 6'd1);
      case (ctrl.op)
        OP_LOAD: begin
          wa <= ca;
          wb <= cb;
          wc <= cc;
          wd <= cd;
        end
        OP_ROUND: begin
          // target rotates A, D, C, B: shift the word ring by one
          wa <= wd;
          wb <= rnd_out;
          wc <= wb;
          wd <= wc;
        end
        OP_CHAIN: begin
          ca <= ca + wa;
          cb <= cb + wb;
          cc <= cc + wc;
          cd <= cd + wd;
        end
        OP_EMIT: begin
          if (emit_load) begin
            ca    <= IV_A;
            cb    <= IV_B;
            cc    <= IV_C;
            cd    <= IV_D;
            count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) digest_data <= '{digest_a: ca, digest_b: cb, digest_c: cc, digest_d: cd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (emit_load) begin
      digest_valid <= 1'b1;
    end else if (digest_ready) begin
      digest_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
